// ===== rtl/adc_ot_pkg.sv =====
// Shared constants, operation codes and types of the averager with overvoltage trip.
package adc_ot_pkg;

	// Default geometry of sample codes and the sample counter
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int COUNT_BITS_DEF  = 16;

	// Reset value of the overvoltage limit register
	localparam int LIMIT_RESET = 787;

	// Voltage scaling: avg/4 + avg/210, kept to 8 bits
	localparam int VOLT_W     = 8;
	localparam int VOLT_SHIFT = 2;
	localparam int VOLT_DIV   = 210;

	// Reciprocal of VOLT_DIV, exact for every code of up to 16 bits
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + VOLT_DIV - 1) / VOLT_DIV;
	localparam int RECIP_BITS  = $clog2(RECIP_MUL + 1);

	// Operation classes handed from the front end to the back end
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_ACCUM   = 2'd0;
	localparam logic [OP_W-1:0] OP_TRIP    = 2'd1;
	localparam logic [OP_W-1:0] OP_CAPTURE = 2'd2;

	// Depth of the queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	// Register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_OVER_LIMIT = 1'b0;

	// Control flags of the result register
	typedef struct packed {
		logic valid;
		logic is_capture;
		logic tripped;
		logic shutdown_now;
	} res_flags_t;

endpackage

// ===== rtl/adc_ot_front.sv =====
// Front end: accepts stream items and classifies them into queue operations.
module adc_ot_front #(
	parameter int SAMPLE_BITS = adc_ot_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   s_valid,
	output logic                                   s_ready,
	input  logic                                   kind,
	input  logic [SAMPLE_BITS-1:0]                 sample_value,
	input  logic [SAMPLE_BITS-1:0]                 over_limit,
	input  logic                                   q_full,
	output logic                                   q_push,
	output logic [adc_ot_pkg::OP_W+SAMPLE_BITS-1:0] q_entry
);
	import adc_ot_pkg::*;

	logic [OP_W-1:0] op;

	// Take a transfer whenever the queue has room
	assign s_ready = !q_full;
	assign q_push  = s_valid && !q_full;

	// Classify: capture request, over-limit sample, or sample to accumulate
	always_comb begin
		if (kind) begin
			op = OP_CAPTURE;
		end else if (sample_value > over_limit) begin
			op = OP_TRIP;
		end else begin
			op = OP_ACCUM;
		end
	end

	assign q_entry = {op, sample_value};

endmodule

// ===== rtl/adc_ot_queue.sv =====
// Short first-in first-out queue that decouples the front end from the back end.
module adc_ot_queue #(
	parameter int WIDTH = 12,
	parameter int DEPTH = adc_ot_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	import adc_ot_pkg::*;

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full       = (fill_q == FILL_W'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/adc_ot_back.sv =====
// Back end: accumulator, iterative divider, voltage scaling and result register.
module adc_ot_back #(
	parameter int SAMPLE_BITS = adc_ot_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = adc_ot_pkg::COUNT_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_valid,
	input  logic [adc_ot_pkg::OP_W+SAMPLE_BITS-1:0] q_entry,
	output logic                                    q_pop,
	input  logic                                    m_ready,
	output adc_ot_pkg::res_flags_t                  res_flags,
	output logic [SAMPLE_BITS-1:0]                  res_avg,
	output logic [adc_ot_pkg::VOLT_W-1:0]           res_volt
);
	import adc_ot_pkg::*;

	localparam int ENTRY_W  = OP_W + SAMPLE_BITS;
	localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
	localparam int STEP_W   = $clog2(SUM_BITS + 1);
	localparam int PROD_W   = SAMPLE_BITS + RECIP_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_VOLT = 2'd3;

	logic [1:0]             state_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [SAMPLE_BITS-1:0] last_avg_q;
	logic                   trip_q;
	logic [SUM_BITS-1:0]    dvd_q;
	logic [COUNT_BITS-1:0]  dvs_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [STEP_W-1:0]      step_q;
	logic [PROD_W-1:0]      prod_q;
	res_flags_t             flags_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [VOLT_W-1:0]      volt_q;

	logic [OP_W-1:0]        head_op;
	logic [SAMPLE_BITS-1:0] head_sample;
	logic                   out_free;
	logic                   count_full;
	logic                   cap_start;
	logic                   emit_now;
	logic                   emit_volt;
	logic [COUNT_BITS:0]    trial;
	logic [COUNT_BITS:0]    trial_diff;
	logic                   trial_ge;
	logic [PROD_W-1:0]      quo_div;
	logic [VOLT_W-1:0]      volt_calc;

	assign head_op     = q_entry[ENTRY_W-1 -: OP_W];
	assign head_sample = q_entry[SAMPLE_BITS-1:0];

	// Output register is free when empty or being drained this cycle
	assign out_free   = !flags_q.valid || m_ready;
	assign count_full = (count_q == {COUNT_BITS{1'b1}});
	assign q_pop      = (state_q == ST_IDLE) && q_valid && out_free;
	assign cap_start  = q_pop && (head_op == OP_CAPTURE) && (count_q != '0);
	assign emit_now   = q_pop && !cap_start;
	assign emit_volt  = (state_q == ST_VOLT) && out_free;

	// One restoring division step: shift in the next dividend bit, try a subtract
	assign trial      = {rem_q, dvd_q[SUM_BITS-1]};
	assign trial_ge   = (trial >= {1'b0, dvs_q});
	assign trial_diff = trial - {1'b0, dvs_q};

	// Scale the stored average: avg/4 plus avg/210 through the reciprocal product
	assign quo_div   = prod_q >> RECIP_SHIFT;
	assign volt_calc = VOLT_W'(last_avg_q >> VOLT_SHIFT) + VOLT_W'(quo_div);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sum_q         <= '0;
			count_q       <= '0;
			last_avg_q    <= '0;
			trip_q        <= 1'b0;
			step_q        <= '0;
			flags_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && (head_op == OP_ACCUM) && !count_full) begin
						sum_q   <= sum_q + SUM_BITS'(head_sample);
						count_q <= count_q + 1'b1;
					end
					if (q_pop && (head_op == OP_TRIP)) begin
						trip_q <= 1'b1;
					end
					if (cap_start) begin
						sum_q   <= '0;
						count_q <= '0;
						step_q  <= STEP_W'(SUM_BITS);
						state_q <= ST_DIV;
					end
					if (emit_now) begin
						flags_q.valid        <= 1'b1;
						flags_q.is_capture   <= (head_op == OP_CAPTURE);
						flags_q.tripped      <= trip_q || (head_op == OP_TRIP);
						flags_q.shutdown_now <= (head_op == OP_TRIP);
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					last_avg_q <= dvd_q[SAMPLE_BITS-1:0];
					state_q    <= ST_VOLT;
				end
				ST_VOLT: begin
					if (emit_volt) begin
						flags_q.valid        <= 1'b1;
						flags_q.is_capture   <= 1'b1;
						flags_q.tripped      <= trip_q;
						flags_q.shutdown_now <= 1'b0;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Drop the result once the consumer takes it and nothing replaces it
			if (m_ready && !emit_now && !emit_volt) begin
				flags_q.valid <= 1'b0;
			end
		end
	end

	// Divider datapath and result payload
	always_ff @(posedge clk) begin
		if (cap_start) begin
			dvd_q <= sum_q;
			dvs_q <= count_q;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[SUM_BITS-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(dvd_q[SAMPLE_BITS-1:0]) * PROD_W'(RECIP_MUL);
		end
		if (emit_now) begin
			avg_q  <= last_avg_q;
			volt_q <= '0;
		end else if (emit_volt) begin
			avg_q  <= last_avg_q;
			volt_q <= volt_calc;
		end
	end

	assign res_flags = flags_q;
	assign res_avg   = avg_q;
	assign res_volt  = volt_q;

	// Trip flag is sticky until reset
	a_trip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		trip_q |=> trip_q)
		else $error("trip flag cleared without reset");

	// Saturated count only leaves saturation through a capture
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		count_full |=> (count_full || (count_q == '0)))
		else $error("sample count wrapped");

	// A finished capture always finds the result register free
	a_volt_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VOLT) |-> out_free)
		else $error("capture result blocked by a pending result");

	// The divider never runs with an exhausted step count
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q != '0))
		else $error("divider step counter underflow");

	// A shutdown pulse never rides on a capture result
	a_shut_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_q.valid && flags_q.shutdown_now) |-> !flags_q.is_capture)
		else $error("shutdown flagged on a capture result");

endmodule

// ===== rtl/adc_average_overvoltage_trip_unit.sv =====
// Top level: sample averager with overvoltage trip, register port and stream ports.
// Every input transfer yields exactly one result transfer, in order. A sample within the
// limit is added to a running sum and count (the count saturates and further samples are
// dropped); a sample above the over_limit register sets the sticky tripped flag and
// reports shutdown_now for that one result. A capture divides sum by count, keeps the mean
// as average_code and reports voltage = (avg/4 + avg/210) mod 256; with no samples it
// reports voltage 0 and keeps the previous average. Samples and empty captures go through
// the back end at one per cycle unless the result stream stalls; a capture with samples
// runs the restoring divider, which retires one quotient bit per cycle, followed by one
// reciprocal multiply and the final add. A two-entry queue keeps the input side taking
// transfers, until it fills, while the back end divides or a result waits.
// over_limit sits at byte address 0 of the register port and resets to 787.
module adc_average_overvoltage_trip_unit #(
	parameter int SAMPLE_BITS = adc_ot_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = adc_ot_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [adc_ot_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [adc_ot_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [adc_ot_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                  pready,
	// Input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample_value
	input  logic                                  s_axis_tuser,  // kind
	// Result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+adc_ot_pkg::VOLT_W+2+7)/8)*8-1:0] m_axis_tdata,
	// m_axis_tdata: average_code, voltage, tripped, shutdown_now
	output logic                                  m_axis_tuser   // is_capture
);
	import adc_ot_pkg::*;

	localparam int ENTRY_W    = OP_W + SAMPLE_BITS;
	localparam int OUT_DATA_W = ((SAMPLE_BITS + VOLT_W + 2 + 7) / 8) * 8;

	logic [SAMPLE_BITS-1:0] over_limit_q;
	logic                   reg_sel;
	logic                   q_full;
	logic                   q_push;
	logic [ENTRY_W-1:0]     q_in;
	logic                   q_pop;
	logic                   q_valid;
	logic [ENTRY_W-1:0]     q_head;
	res_flags_t             res_flags;
	logic [SAMPLE_BITS-1:0] res_avg;
	logic [VOLT_W-1:0]      res_volt;

	// Register port decode
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_OVER_LIMIT);
	assign prdata  = reg_sel ? APB_DATA_W'(over_limit_q) : '0;

	// Write the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_limit_q <= SAMPLE_BITS'(LIMIT_RESET);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			over_limit_q <= pwdata[SAMPLE_BITS-1:0];
		end
	end

	adc_ot_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.s_valid      (s_axis_tvalid),
		.s_ready      (s_axis_tready),
		.kind         (s_axis_tuser),
		.sample_value (s_axis_tdata[SAMPLE_BITS-1:0]),
		.over_limit   (over_limit_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	adc_ot_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	adc_ot_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_head),
		.q_pop     (q_pop),
		.m_ready   (m_axis_tready),
		.res_flags (res_flags),
		.res_avg   (res_avg),
		.res_volt  (res_volt)
	);

	// Pack the result transfer
	assign m_axis_tvalid = res_flags.valid;
	assign m_axis_tuser  = res_flags.is_capture;
	assign m_axis_tdata  = OUT_DATA_W'({res_flags.shutdown_now, res_flags.tripped,
		res_volt, res_avg});

endmodule
